/* rtl/srtf_pkg.sv */
// Package for the shortest-remaining-time tick scheduler.
// Holds the action codes, field widths and saturation limits.
// No dependencies.
package srtf_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    localparam int ACT_W   = 2;
    localparam int FIELD_W = 16;
    localparam int RUN_W   = 4;
    localparam int SUM_W   = 20;

    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NOP   = 2'd3;

    localparam logic [FIELD_W-1:0] WAIT_MAX = 16'hFFFF;
    localparam logic [SUM_W-1:0]   SUM_MAX  = 20'hFFFFF;

endpackage

/* rtl/srtf_entry_ram.sv */
// Process table memory: one write port, one read port, registered read data.
// Stores arrival, burst and remaining time of each process. No dependencies.
module srtf_entry_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/srtf_tick_scheduler.sv */
// Top level of the shortest-remaining-time tick scheduler.
// Uses srtf_pkg and srtf_entry_ram.
//
// Usage: one input channel (action, burst_len, arrive_at with in_valid and
// in_stall) and one result channel (run_id, idle, finished, wait_time,
// total_wait, all_done, table_full with out_valid and out_stall). Every
// input transaction yields exactly one result transaction, in order.
// A clear or load passes through the emit state into the output register.
// A tick scans the process table one entry per cycle through the memory read
// port, then updates the chosen entry and the time and emits its result; when
// a process finishes, a wait state and an accumulate state that adds its wait
// come before the emit.
// The block works on one transaction at a time; in_stall is high while a
// transaction is being processed. A finished result sits in the output
// register, and the next input is accepted while it waits there. If the
// receiver still stalls when the next result is ready, processing holds
// until the output register frees up. Reset empties the table, zeroes time
// and the wait total; the table memory itself is not cleared.
module srtf_tick_scheduler #(
    parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEF,
    parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [srtf_pkg::ACT_W-1:0]   action,
    input  logic [srtf_pkg::FIELD_W-1:0] burst_len,
    input  logic [srtf_pkg::FIELD_W-1:0] arrive_at,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [srtf_pkg::RUN_W-1:0]   run_id,
    output logic                         idle,
    output logic                         finished,
    output logic [srtf_pkg::FIELD_W-1:0] wait_time,
    output logic [srtf_pkg::SUM_W-1:0]   total_wait,
    output logic                         all_done,
    output logic                         table_full
);

    import srtf_pkg::*;

    localparam int IDX_W   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W   = $clog2(MAX_PROCS + 1);
    localparam int ENTRY_W = 3 * FIELD_W;
    localparam int USED_W  = FIELD_W + 1;
    localparam int ARR_CW  = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;
    localparam int WAIT_CW = (TIME_BITS > USED_W) ? TIME_BITS : USED_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_ACCUM  = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]           state_reg;
    logic [CNT_W-1:0]     loaded_reg;
    logic [CNT_W-1:0]     undone_reg;
    logic [MAX_PROCS-1:0] done_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [SUM_W-1:0]     wait_sum_reg;
    logic [CNT_W-1:0]     issue_reg;
    logic                 pend_vld_reg;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic                 found_reg;
    logic                 res_fin_reg;
    logic                 out_valid_reg;

    logic [IDX_W-1:0]     best_idx_reg;
    logic [FIELD_W-1:0]   best_arr_reg;
    logic [FIELD_W-1:0]   best_burst_reg;
    logic [FIELD_W-1:0]   best_rem_reg;
    logic [USED_W-1:0]    used_reg;
    logic [RUN_W-1:0]     res_run_reg;
    logic                 res_idle_reg;
    logic [FIELD_W-1:0]   res_wait_reg;
    logic                 res_full_reg;

    logic [RUN_W-1:0]     run_id_reg;
    logic                 idle_reg;
    logic                 finished_reg;
    logic [FIELD_W-1:0]   wait_time_reg;
    logic [SUM_W-1:0]     total_wait_reg;
    logic                 all_done_reg;
    logic                 table_full_reg;

    logic                 accept;
    logic                 is_full;
    logic                 load_wr;
    logic                 scan_rd;
    logic                 emit_go;
    logic                 eligible;
    logic                 better;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic [ENTRY_W-1:0]   rd_data;
    logic [FIELD_W-1:0]   rd_arr;
    logic [FIELD_W-1:0]   rd_burst;
    logic [FIELD_W-1:0]   rd_rem;
    logic [FIELD_W-1:0]   new_rem;
    logic [TIME_BITS-1:0] now_inc;
    logic [WAIT_CW-1:0]   diff;
    logic [SUM_W:0]       sum_wide;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign is_full  = (loaded_reg >= CNT_W'(MAX_PROCS));
    assign load_wr  = accept && (action == ACT_LOAD) && !is_full;
    assign scan_rd  = (state_reg == S_SCAN) && (issue_reg < loaded_reg);
    assign emit_go  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    assign rd_arr   = rd_data[3*FIELD_W-1:2*FIELD_W];
    assign rd_burst = rd_data[2*FIELD_W-1:FIELD_W];
    assign rd_rem   = rd_data[FIELD_W-1:0];

    // Arrival is compared against the current time before it advances.
    assign eligible = !done_reg[pend_idx_reg]
                      && (ARR_CW'(rd_arr) <= ARR_CW'(now_reg));
    assign better   = !found_reg || (rd_rem < best_rem_reg);

    assign new_rem  = (best_rem_reg != '0) ? best_rem_reg - 1'b1 : best_rem_reg;
    assign now_inc  = (now_reg != '1) ? now_reg + 1'b1 : now_reg;
    assign diff     = WAIT_CW'(now_reg) - WAIT_CW'(used_reg);
    assign sum_wide = {1'b0, wait_sum_reg} + (SUM_W + 1)'(res_wait_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = best_idx_reg;
        wr_data = {best_arr_reg, best_burst_reg, new_rem};
        if (load_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = loaded_reg[IDX_W-1:0];
            wr_data = {arrive_at, burst_len, burst_len};
        end
        else if ((state_reg == S_UPDATE) && found_reg)
        begin
            wr_en = 1'b1;
        end
    end

    srtf_entry_ram #(
        .DEPTH  (MAX_PROCS),
        .ADDR_W (IDX_W),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (scan_rd),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loaded_reg    <= '0;
            undone_reg    <= '0;
            done_reg      <= '0;
            now_reg       <= '0;
            wait_sum_reg  <= '0;
            issue_reg     <= '0;
            pend_vld_reg  <= 1'b0;
            pend_idx_reg  <= '0;
            found_reg     <= 1'b0;
            res_fin_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_fin_reg <= 1'b0;
                        priority if (action == ACT_CLEAR)
                        begin
                            loaded_reg   <= '0;
                            undone_reg   <= '0;
                            done_reg     <= '0;
                            now_reg      <= '0;
                            wait_sum_reg <= '0;
                            state_reg    <= S_EMIT;
                        end
                        else if (action == ACT_TICK)
                        begin
                            issue_reg    <= '0;
                            pend_vld_reg <= 1'b0;
                            found_reg    <= 1'b0;
                            state_reg    <= S_SCAN;
                        end
                        else
                        begin
                            if (load_wr)
                            begin
                                done_reg[loaded_reg[IDX_W-1:0]] <= (burst_len == '0);
                                loaded_reg <= loaded_reg + 1'b1;
                                if (burst_len != '0)
                                begin
                                    undone_reg <= undone_reg + 1'b1;
                                end
                            end
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_SCAN:
                begin
                    pend_vld_reg <= scan_rd;
                    if (scan_rd)
                    begin
                        pend_idx_reg <= issue_reg[IDX_W-1:0];
                        issue_reg    <= issue_reg + 1'b1;
                    end
                    if (pend_vld_reg && eligible && better)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (!scan_rd && !pend_vld_reg)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    now_reg <= now_inc;
                    if (found_reg && (new_rem == '0))
                    begin
                        done_reg[best_idx_reg] <= 1'b1;
                        undone_reg  <= undone_reg - 1'b1;
                        res_fin_reg <= 1'b1;
                        state_reg   <= S_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_ACCUM;
                end
                S_ACCUM:
                begin
                    wait_sum_reg <= (sum_wide > (SUM_W + 1)'(SUM_MAX))
                                    ? SUM_MAX : sum_wide[SUM_W-1:0];
                    state_reg    <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers: best candidate, result fields and output register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_run_reg  <= '0;
            res_idle_reg <= 1'b0;
            res_wait_reg <= '0;
            res_full_reg <= (action == ACT_LOAD) && is_full;
        end
        if ((state_reg == S_SCAN) && pend_vld_reg && eligible && better)
        begin
            best_idx_reg   <= pend_idx_reg;
            best_arr_reg   <= rd_arr;
            best_burst_reg <= rd_burst;
            best_rem_reg   <= rd_rem;
        end
        if (state_reg == S_UPDATE)
        begin
            res_idle_reg <= !found_reg;
            res_run_reg  <= found_reg ? RUN_W'(best_idx_reg) : '0;
            used_reg     <= USED_W'(best_arr_reg) + USED_W'(best_burst_reg);
        end
        // Time has already advanced here, so now_reg is the finish time.
        if (state_reg == S_WAIT)
        begin
            if (WAIT_CW'(now_reg) > WAIT_CW'(used_reg))
            begin
                res_wait_reg <= (diff > WAIT_CW'(WAIT_MAX))
                                ? WAIT_MAX : diff[FIELD_W-1:0];
            end
            else
            begin
                res_wait_reg <= '0;
            end
        end
        if (emit_go)
        begin
            run_id_reg     <= res_run_reg;
            idle_reg       <= res_idle_reg;
            finished_reg   <= res_fin_reg;
            wait_time_reg  <= res_wait_reg;
            total_wait_reg <= wait_sum_reg;
            all_done_reg   <= (undone_reg == '0);
            table_full_reg <= res_full_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign run_id     = run_id_reg;
    assign idle       = idle_reg;
    assign finished   = finished_reg;
    assign wait_time  = wait_time_reg;
    assign total_wait = total_wait_reg;
    assign all_done   = all_done_reg;
    assign table_full = table_full_reg;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the shortest-remaining-time tick scheduler.
// Depends on srtf_pkg and srtf_tick_scheduler; carries its own scheduler predictor.
`timescale 1ns / 1ps

module tb;
    import srtf_pkg::*;

    localparam int PROC_SLOTS  = MAX_PROCS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_CAP  = 40;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [RUN_W-1:0]   run_id;
        logic               idle;
        logic               finished;
        logic [FIELD_W-1:0] wait_time;
        logic [SUM_W-1:0]   total_wait;
        logic               all_done;
        logic               table_full;
    } sched_res_t;

    typedef struct packed {
        logic [ACT_W-1:0]   act;
        logic [FIELD_W-1:0] burst;
        logic [FIELD_W-1:0] arrive;
        logic [7:0]         reps;
        logic               typed;
        sched_res_t         res;
    } stim_row_t;

    // Results that can be read off directly: no process has run and no wait has accrued.
    localparam sched_res_t RES_EMPTY      = '{4'd0, 1'b0, 1'b0, 16'd0, 20'd0, 1'b1, 1'b0};
    localparam sched_res_t RES_IDLE_EMPTY = '{4'd0, 1'b1, 1'b0, 16'd0, 20'd0, 1'b1, 1'b0};
    localparam sched_res_t RES_PENDING    = '{4'd0, 1'b0, 1'b0, 16'd0, 20'd0, 1'b0, 1'b0};
    localparam sched_res_t RES_REFUSED    = '{4'd0, 1'b0, 1'b0, 16'd0, 20'd0, 1'b1, 1'b1};
    localparam sched_res_t RES_NONE       = '0;

    localparam int DIR_ROWS = 19;
    localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
        '{ACT_CLEAR, 16'h0000, 16'h0000, 8'd1,  1'b1, RES_EMPTY},
        '{ACT_TICK,  16'hFFFF, 16'hFFFF, 8'd1,  1'b1, RES_IDLE_EMPTY},
        '{ACT_NOP,   16'hFFFF, 16'hFFFF, 8'd1,  1'b1, RES_EMPTY},
        '{ACT_LOAD,  16'h0000, 16'h0000, 8'd1,  1'b1, RES_EMPTY},
        '{ACT_LOAD,  16'h0003, 16'h0000, 8'd1,  1'b1, RES_PENDING},
        '{ACT_LOAD,  16'h0001, 16'h0002, 8'd1,  1'b0, RES_NONE},
        '{ACT_LOAD,  16'hFFFF, 16'hFFFF, 8'd1,  1'b0, RES_NONE},
        '{ACT_LOAD,  16'h0002, 16'h0001, 8'd1,  1'b0, RES_NONE},
        '{ACT_TICK,  16'h0000, 16'h0000, 8'd8,  1'b0, RES_NONE},
        '{ACT_CLEAR, 16'hFFFF, 16'hFFFF, 8'd1,  1'b1, RES_EMPTY},
        '{ACT_LOAD,  16'h0000, 16'h0000, 8'd16, 1'b1, RES_EMPTY},
        '{ACT_LOAD,  16'h0005, 16'h0000, 8'd1,  1'b1, RES_REFUSED},
        '{ACT_TICK,  16'h0000, 16'h0000, 8'd1,  1'b1, RES_IDLE_EMPTY},
        '{ACT_CLEAR, 16'h0000, 16'h0000, 8'd1,  1'b1, RES_EMPTY},
        '{ACT_LOAD,  16'h0004, 16'h0000, 8'd2,  1'b0, RES_NONE},
        '{ACT_LOAD,  16'h0002, 16'h0003, 8'd1,  1'b0, RES_NONE},
        '{ACT_TICK,  16'h0000, 16'h0000, 8'd12, 1'b0, RES_NONE},
        '{ACT_LOAD,  16'h0001, 16'h8000, 8'd1,  1'b0, RES_NONE},
        '{ACT_TICK,  16'h0000, 16'h0000, 8'd3,  1'b0, RES_NONE}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [ACT_W-1:0]   action = '0;
    logic [FIELD_W-1:0] burst_len = '0;
    logic [FIELD_W-1:0] arrive_at = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [RUN_W-1:0]   run_id;
    logic               idle;
    logic               finished;
    logic [FIELD_W-1:0] wait_time;
    logic [SUM_W-1:0]   total_wait;
    logic               all_done;
    logic               table_full;

    srtf_tick_scheduler uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .burst_len  (burst_len),
        .arrive_at  (arrive_at),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .run_id     (run_id),
        .idle       (idle),
        .finished   (finished),
        .wait_time  (wait_time),
        .total_wait (total_wait),
        .all_done   (all_done),
        .table_full (table_full)
    );

    always #5 clk = ~clk;

    // Scheduler state as the predictor sees it.
    logic [FIELD_W-1:0] slot_arrival [PROC_SLOTS];
    logic [FIELD_W-1:0] slot_left    [PROC_SLOTS];
    logic [FIELD_W-1:0] slot_burst   [PROC_SLOTS];
    bit                 slot_done    [PROC_SLOTS];
    int unsigned        slot_count = 0;
    logic [FIELD_W-1:0] sched_now = '0;
    logic [SUM_W-1:0]   wait_total = '0;

    sched_res_t  pending_results [$];
    int unsigned fail_count = 0;
    int unsigned txn_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    function automatic bit all_finished();
        int unsigned i;
        for (i = 0; i < slot_count; i++)
            if (!slot_done[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic sched_res_t sched_predict(input logic [ACT_W-1:0] act,
                                                 input logic [FIELD_W-1:0] b,
                                                 input logic [FIELD_W-1:0] a);
        sched_res_t  r;
        int unsigned i;
        int unsigned pick;
        bit          found;
        logic [16:0] used;
        logic [16:0] late;
        logic [20:0] sum;
        r = '0;
        pick = 0;
        found = 1'b0;
        case (act)
            ACT_CLEAR:
            begin
                for (i = 0; i < PROC_SLOTS; i++)
                    slot_done[i] = 1'b0;
                slot_count = 0;
                sched_now = '0;
                wait_total = '0;
            end
            ACT_LOAD:
            begin
                if (slot_count >= PROC_SLOTS)
                begin
                    r.table_full = 1'b1;
                end
                else
                begin
                    slot_arrival[slot_count] = a;
                    slot_burst[slot_count] = b;
                    slot_left[slot_count] = b;
                    slot_done[slot_count] = (b == '0);
                    slot_count++;
                end
            end
            ACT_TICK:
            begin
                for (i = 0; i < slot_count; i++)
                begin
                    if (!slot_done[i] && slot_arrival[i] <= sched_now)
                        if (!found || slot_left[i] < slot_left[pick])
                        begin
                            pick = i;
                            found = 1'b1;
                        end
                end
                if (sched_now != '1)
                    sched_now = sched_now + 1'b1;
                if (!found)
                begin
                    r.idle = 1'b1;
                end
                else
                begin
                    r.run_id = RUN_W'(pick);
                    if (slot_left[pick] != '0)
                        slot_left[pick] = slot_left[pick] - 1'b1;
                    if (slot_left[pick] == '0)
                    begin
                        slot_done[pick] = 1'b1;
                        r.finished = 1'b1;
                        used = {1'b0, slot_arrival[pick]} + {1'b0, slot_burst[pick]};
                        // Once time has saturated the difference can go negative.
                        late = ({1'b0, sched_now} > used) ? {1'b0, sched_now} - used : '0;
                        r.wait_time = (late > {1'b0, WAIT_MAX}) ? WAIT_MAX : late[15:0];
                        sum = {1'b0, wait_total} + {5'd0, r.wait_time};
                        wait_total = (sum > {1'b0, SUM_MAX}) ? SUM_MAX : sum[SUM_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        r.total_wait = wait_total;
        r.all_done = all_finished();
        return r;
    endfunction

    // Present one transaction, hold it until accepted, then log its expected result.
    task automatic issue_txn(input logic [ACT_W-1:0] act, input logic [FIELD_W-1:0] b,
                             input logic [FIELD_W-1:0] a, input bit use_typed = 1'b0,
                             input sched_res_t typed_res = '0);
        sched_res_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        burst_len <= b;
        arrive_at <= a;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = sched_predict(act, b, a);
        pending_results.push_back(use_typed ? typed_res : predicted);
        if (act != ACT_NOP)
            txn_count++;
    endtask

    // Mostly well-formed runs: clear, a batch of loads, then ticks until done or a tick
    // cap is reached, with stray transactions mixed in.
    task automatic random_batch(input int unsigned goal);
        int unsigned        stop_at;
        int unsigned        nproc;
        int unsigned        tick_cap;
        int unsigned        k;
        int unsigned        t;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] a;
        stop_at = txn_count + goal;
        while (txn_count < stop_at)
        begin
            issue_txn(ACT_CLEAR, 16'($urandom), 16'($urandom));
            nproc = $urandom_range(1, PROC_SLOTS);
            if ($urandom_range(0, 9) == 0)
                nproc = PROC_SLOTS + $urandom_range(1, 3);
            for (k = 0; k < nproc; k++)
            begin
                case ($urandom_range(0, 19))
                    0:       b = '0;
                    1:       b = 16'($urandom);
                    default: b = 16'($urandom_range(1, 6));
                endcase
                if ($urandom_range(0, 19) == 0)
                    a = 16'($urandom);
                else
                    a = sched_now + 16'($urandom_range(0, 12));
                issue_txn(ACT_LOAD, b, a);
                if ($urandom_range(0, 3) == 0)
                    issue_txn(ACT_TICK, 16'($urandom), 16'($urandom));
            end
            tick_cap = $urandom_range(20, 80);
            for (t = 0; t < tick_cap && !all_finished(); t++)
            begin
                if ($urandom_range(0, 11) == 0)
                    issue_txn(ACT_W'($urandom), 16'($urandom), 16'($urandom));
                else
                    issue_txn(ACT_TICK, 16'($urandom), 16'($urandom));
            end
            repeat ($urandom_range(1, 3))
                issue_txn(ACT_TICK, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic check_field(input string name, input logic [SUM_W-1:0] expv,
                               input logic [SUM_W-1:0] actv);
        if (expv !== actv)
        begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $display("%0t: %s expected %0h actual %0h", $time, name, expv, actv);
        end
    endtask

    always @(posedge clk)
    begin
        sched_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $display("%0t: result transaction with nothing expected", $time);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("run_id", SUM_W'(want.run_id), SUM_W'(run_id));
                check_field("idle", SUM_W'(want.idle), SUM_W'(idle));
                check_field("finished", SUM_W'(want.finished), SUM_W'(finished));
                check_field("wait_time", SUM_W'(want.wait_time), SUM_W'(wait_time));
                check_field("total_wait", want.total_wait, total_wait);
                check_field("all_done", SUM_W'(want.all_done), SUM_W'(all_done));
                check_field("table_full", SUM_W'(want.table_full), SUM_W'(table_full));
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        int r;
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 10;
        recv_idle_pct <= 54;
        for (r = 0; r < DIR_ROWS; r++)
            for (n = 0; n < DIR_TAB[r].reps; n++)
                issue_txn(DIR_TAB[r].act, DIR_TAB[r].burst, DIR_TAB[r].arrive,
                          DIR_TAB[r].typed, DIR_TAB[r].res);
        random_batch(100);

        send_idle_pct = 54;
        recv_idle_pct <= 10;
        random_batch(100);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        random_batch(100);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
